/* design/cpd_pkg.sv */
// Shared types, constants and fixed-point helpers of the camera point projection block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package cpd_pkg;

	// image and depth scaling
	localparam int IMG_WIDTH   = 640;
	localparam int IMG_HEIGHT  = 480;
	localparam int DEPTH_SCALE = 1000;
	localparam int DS_W        = $clog2(DEPTH_SCALE + 1);
	localparam int DPROD_W     = 31 + DS_W + 1;

	// fixed point
	localparam int FRAC = 28;
	localparam logic signed [63:0] LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] NLIM    = -LIM;
	localparam logic signed [64:0] LIM65   = 65'sh0_3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] NLIM65  = -LIM65;
	localparam logic signed [63:0] ONE_Q28 = 64'sh0000_0000_1000_0000;
	localparam int COL_W = 48;

	// divider: 61 quotient bits, 32-bit divisor
	localparam int DIV_N_W  = 61;
	localparam int DIV_D_W  = 32;
	localparam int DIV_BITS = DIV_N_W;
	localparam int DIV_LAT  = DIV_BITS + 2;

	// multiplier latency
	localparam int MUL_LAT = 5;

	// back-end schedule, cycles after the item sits in the first back register
	localparam int T_A   = DIV_LAT;
	localparam int T_C   = T_A + MUL_LAT + 1;
	localparam int T_D   = T_C + MUL_LAT;
	localparam int T_E   = T_D + MUL_LAT;
	localparam int T_F   = T_E + MUL_LAT;
	localparam int T_G   = T_F + 2;
	localparam int T_H   = T_G + MUL_LAT;
	localparam int T_I   = T_H + 2 + MUL_LAT;
	localparam int T_COL = T_I + 2;

	localparam int XN_DLY   = T_G - T_A;
	localparam int R2_DLY   = T_D - T_C;
	localparam int K1R2_DLY = T_F - T_D;
	localparam int K2R4_DLY = T_F - T_E;
	localparam int XY2_DLY  = T_G - T_C;
	localparam int TX2_DLY  = T_G - T_C - 1;
	localparam int META_DLY = T_COL;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X, REG_FOCAL_Y, REG_CENTER_X, REG_CENTER_Y,
		REG_RADIAL_K1, REG_RADIAL_K2, REG_RADIAL_K3, REG_TANGENTIAL
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pixel_col;
		logic signed [15:0] pixel_row;
		logic [15:0]        depth_code;
		logic               in_view;
	} out_item_t;

	typedef struct packed {
		logic [31:0]        focal_x;
		logic [31:0]        focal_y;
		logic [31:0]        center_x;
		logic [31:0]        center_y;
		logic signed [31:0] radial_k1;
		logic signed [31:0] radial_k2;
		logic signed [31:0] radial_k3;
		logic [63:0]        tangential_pair;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               zpos;
		logic [15:0]        depth;
	} qent_t;

	typedef struct packed {
		logic        zpos;
		logic [15:0] depth;
	} meta_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
	                                               input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > LIM65) return LIM;
		if (s < NLIM65) return NLIM;
		return s[63:0];
	endfunction

	// Q.16 to integer, half away from zero
	function automatic logic signed [COL_W-1:0] round_q16(input logic signed [63:0] v);
		logic [62:0] mag;
		logic [63:0] t;
		logic [COL_W-1:0] m;
		mag = v[63] ? 63'(-v) : v[62:0];
		t = {1'b0, mag} + 64'h8000;
		m = t[63:16];
		return v[63] ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [COL_W-1:0] c);
		if (c > $signed(COL_W'(32767))) return 16'sh7FFF;
		if (c < $signed(-COL_W'(32768))) return 16'sh8000;
		return c[15:0];
	endfunction

endpackage
`default_nettype wire

/* design/cpd_mul.sv */
// Pipelined signed fixed-point multiplier: exact product, >> 28 rounded, saturated.
// Built from four partial products of the 32-bit and 30-bit halves over five stages; uses cpd_pkg.
`default_nettype none
module cpd_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);
	import cpd_pkg::*;

	function automatic logic [61:0] mag62(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > LIM) c = LIM;
		if (v < NLIM) c = NLIM;
		return c[63] ? 62'(-c) : c[61:0];
	endfunction

	logic [61:0]  ma_s1, mb_s1;
	logic         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]  p0_s2, p0_s3;
	logic [61:0]  p1_s2, p2_s2;
	logic [59:0]  p3_s2, p3_s3;
	logic [62:0]  mid_s3;
	logic [123:0] tot_s4;
	logic [95:0]  sh;
	logic [61:0]  m;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= mag62(a);
			mb_s1  <= mag62(b);
			neg_s1 <= a[63] ^ b[63];

			p0_s2  <= ma_s1[31:0] * mb_s1[31:0];
			p1_s2  <= ma_s1[31:0] * mb_s1[61:32];
			p2_s2  <= 62'(ma_s1[61:32] * mb_s1[31:0]);
			p3_s2  <= ma_s1[61:32] * mb_s1[61:32];
			neg_s2 <= neg_s1;

			mid_s3 <= 63'(p1_s2) + 63'(p2_s2);
			p0_s3  <= p0_s2;
			p3_s3  <= p3_s2;
			neg_s3 <= neg_s2;

			tot_s4 <= {p3_s3, p0_s3} + 124'({mid_s3, 32'd0}) + (124'd1 << (FRAC - 1));
			neg_s4 <= neg_s3;

			p <= neg_s4 ? -signed'({2'b00, m}) : signed'({2'b00, m});
		end
	end

	always_comb begin
		sh = tot_s4[123:FRAC];
		m  = (sh > 96'(LIM)) ? LIM[61:0] : sh[61:0];
	end

endmodule
`default_nettype wire

/* design/cpd_div.sv */
// Pipelined restoring divider: round(num * 2^28 / den), half away from zero, den > 0.
// One quotient bit per stage; uses cpd_pkg.
`default_nettype none
module cpd_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic signed [63:0] quo
);
	import cpd_pkg::*;

	logic [DIV_N_W-1:0] nr_q  [DIV_BITS+1];
	logic [DIV_N_W-1:0] qt_q  [DIV_BITS+1];
	logic [DIV_D_W-1:0] rem_q [DIV_BITS+1];
	logic [DIV_D_W-1:0] dv_q  [DIV_BITS+1];
	logic               neg_q [DIV_BITS+1];

	logic [DIV_N_W-1:0] nr_n  [DIV_BITS];
	logic [DIV_N_W-1:0] qt_n  [DIV_BITS];
	logic [DIV_D_W-1:0] rem_n [DIV_BITS];
	logic [31:0]        mag;

	assign mag = num[31] ? 32'(-num) : 32'(num);

	always_comb begin
		logic [DIV_D_W:0] t;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_q[i], nr_q[i][DIV_N_W-1]};
			nr_n[i] = nr_q[i] << 1;
			if (t >= {1'b0, dv_q[i]}) begin
				rem_n[i] = DIV_D_W'(t - {1'b0, dv_q[i]});
				qt_n[i]  = {qt_q[i][DIV_N_W-2:0], 1'b1};
			end else begin
				rem_n[i] = t[DIV_D_W-1:0];
				qt_n[i]  = {qt_q[i][DIV_N_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// numerator m*2^29 + den over 2*den gives the rounded quotient
			nr_q[0]  <= DIV_N_W'({mag, 29'd0}) + DIV_N_W'(den[30:0]);
			dv_q[0]  <= {den[30:0], 1'b0};
			rem_q[0] <= '0;
			qt_q[0]  <= '0;
			neg_q[0] <= num[31];
			for (int i = 0; i < DIV_BITS; i++) begin
				nr_q[i+1]  <= nr_n[i];
				qt_q[i+1]  <= qt_n[i];
				rem_q[i+1] <= rem_n[i];
				dv_q[i+1]  <= dv_q[i];
				neg_q[i+1] <= neg_q[i];
			end
			quo <= neg_q[DIV_BITS] ? -signed'(64'(qt_q[DIV_BITS]))
			                       : signed'(64'(qt_q[DIV_BITS]));
		end
	end

endmodule
`default_nettype wire

/* design/cpd_queue.sv */
// Short flop-based FIFO between the front and the back of the projection block.
// Uses cpd_pkg for the entry type and depth.
`default_nettype none
module cpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cpd_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output cpd_pkg::qent_t pop_data
);
	import cpd_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* design/cpd_front.sv */
// Front end: takes input items, classifies the depth sign and forms the depth code.
// Feeds cpd_queue; uses cpd_pkg.
`default_nettype none
module cpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpd_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              push,
	output cpd_pkg::qent_t    push_data
);
	import cpd_pkg::*;

	logic               f_valid_q;
	qent_t              f_data_q;
	qent_t              cls;
	logic               accept;
	logic [DPROD_W-1:0] dprod;
	logic [DPROD_W-17:0] dq;

	assign push      = f_valid_q && !q_full;
	assign in_stall  = f_valid_q && q_full;
	assign accept    = in_valid && !in_stall;
	assign push_data = f_data_q;

	always_comb begin
		dprod = DPROD_W'(in_item.point_z[30:0]) * DPROD_W'(DEPTH_SCALE) + DPROD_W'(17'h8000);
		dq    = dprod[DPROD_W-1:16];
		cls.x    = in_item.point_x;
		cls.y    = in_item.point_y;
		cls.z    = in_item.point_z;
		cls.zpos = (in_item.point_z > 32'sd0);
		if (!cls.zpos) cls.depth = '0;
		else if (dq > (DPROD_W-16)'(16'hFFFF)) cls.depth = 16'hFFFF;
		else cls.depth = dq[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) f_valid_q <= 1'b0;
		else if (accept) f_valid_q <= 1'b1;
		else if (push) f_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) f_data_q <= cls;
	end

endmodule
`default_nettype wire

/* design/cpd_back.sv */
// Back end: divide, distortion polynomial, focal scaling, rounding and bounds check.
// Instances of cpd_div and cpd_mul; the whole pipeline advances together; uses cpd_pkg.
`default_nettype none
module cpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cpd_pkg::cfg_t      cfg,
	input  logic               q_nonempty,
	input  cpd_pkg::qent_t     pop_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output cpd_pkg::out_item_t out_item
);
	import cpd_pkg::*;

	logic en;
	assign en  = !out_valid || !out_stall;
	assign pop = en && q_nonempty;

	logic signed [63:0] k1, k2, k3, p1, p2, fx, fy, ctx, cty;
	assign k1  = 64'(cfg.radial_k1);
	assign k2  = 64'(cfg.radial_k2);
	assign k3  = 64'(cfg.radial_k3);
	assign p1  = 64'(signed'(cfg.tangential_pair[63:32]));
	assign p2  = 64'(signed'(cfg.tangential_pair[31:0]));
	assign fx  = signed'(64'(cfg.focal_x));
	assign fy  = signed'(64'(cfg.focal_y));
	assign ctx = signed'(64'(cfg.center_x));
	assign cty = signed'(64'(cfg.center_y));

	qent_t b0_q;
	logic  b0_vld_q;
	logic  vld_dl_q  [META_DLY];
	meta_t meta_dl_q [META_DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_vld_q <= 1'b0;
			for (int i = 0; i < META_DLY; i++) vld_dl_q[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			b0_vld_q    <= q_nonempty;
			vld_dl_q[0] <= b0_vld_q;
			for (int i = 1; i < META_DLY; i++) vld_dl_q[i] <= vld_dl_q[i-1];
			out_valid <= vld_dl_q[META_DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b0_q <= pop_data;
			meta_dl_q[0] <= '{zpos: b0_q.zpos, depth: b0_q.depth};
			for (int i = 1; i < META_DLY; i++) meta_dl_q[i] <= meta_dl_q[i-1];
		end
	end

	// normalized coordinates
	logic signed [63:0] xn, yn;
	cpd_div u_divx (.clk(clk), .en(en), .num(b0_q.x), .den(b0_q.z), .quo(xn));
	cpd_div u_divy (.clk(clk), .en(en), .num(b0_q.y), .den(b0_q.z), .quo(yn));

	// squares and cross term
	logic signed [63:0] xx, yy, pxy;
	cpd_mul u_xx  (.clk(clk), .en(en), .a(xn), .b(xn), .p(xx));
	cpd_mul u_yy  (.clk(clk), .en(en), .a(yn), .b(yn), .p(yy));
	cpd_mul u_pxy (.clk(clk), .en(en), .a(xn), .b(yn), .p(pxy));

	logic signed [63:0] xy2_q, r2_q, tx_q, ty_q, tx2_q, ty2_q;
	always_ff @(posedge clk) begin
		if (en) begin
			xy2_q <= sat_add(pxy, pxy);
			r2_q  <= sat_add(xx, yy);
			tx_q  <= sat_add(xx, xx);
			ty_q  <= sat_add(yy, yy);
			tx2_q <= sat_add(r2_q, tx_q);
			ty2_q <= sat_add(r2_q, ty_q);
		end
	end

	// radial powers
	logic signed [63:0] r4, k1r2, r6, k2r4, k3r6;
	logic signed [63:0] r2_dl_q   [R2_DLY];
	logic signed [63:0] k1r2_dl_q [K1R2_DLY];
	logic signed [63:0] k2r4_dl_q [K2R4_DLY];

	cpd_mul u_r4   (.clk(clk), .en(en), .a(r2_q), .b(r2_q), .p(r4));
	cpd_mul u_k1r2 (.clk(clk), .en(en), .a(k1), .b(r2_q), .p(k1r2));
	cpd_mul u_r6   (.clk(clk), .en(en), .a(r4), .b(r2_dl_q[R2_DLY-1]), .p(r6));
	cpd_mul u_k2r4 (.clk(clk), .en(en), .a(k2), .b(r4), .p(k2r4));
	cpd_mul u_k3r6 (.clk(clk), .en(en), .a(k3), .b(r6), .p(k3r6));

	always_ff @(posedge clk) begin
		if (en) begin
			r2_dl_q[0]   <= r2_q;
			k1r2_dl_q[0] <= k1r2;
			k2r4_dl_q[0] <= k2r4;
			for (int i = 1; i < R2_DLY; i++) r2_dl_q[i] <= r2_dl_q[i-1];
			for (int i = 1; i < K1R2_DLY; i++) k1r2_dl_q[i] <= k1r2_dl_q[i-1];
			for (int i = 1; i < K2R4_DLY; i++) k2r4_dl_q[i] <= k2r4_dl_q[i-1];
		end
	end

	logic signed [63:0] suma_q, sumb_q, rad_q;
	always_ff @(posedge clk) begin
		if (en) begin
			suma_q <= sat_add(ONE_Q28, k1r2_dl_q[K1R2_DLY-1]);
			sumb_q <= sat_add(k2r4_dl_q[K2R4_DLY-1], k3r6);
			rad_q  <= sat_add(suma_q, sumb_q);
		end
	end

	// align the linear terms with the radial factor
	logic signed [63:0] xn_dl_q  [XN_DLY];
	logic signed [63:0] yn_dl_q  [XN_DLY];
	logic signed [63:0] xy2_dl_q [XY2_DLY];
	logic signed [63:0] tx2_dl_q [TX2_DLY];
	logic signed [63:0] ty2_dl_q [TX2_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			xn_dl_q[0]  <= xn;
			yn_dl_q[0]  <= yn;
			xy2_dl_q[0] <= xy2_q;
			tx2_dl_q[0] <= tx2_q;
			ty2_dl_q[0] <= ty2_q;
			for (int i = 1; i < XN_DLY; i++) begin
				xn_dl_q[i] <= xn_dl_q[i-1];
				yn_dl_q[i] <= yn_dl_q[i-1];
			end
			for (int i = 1; i < XY2_DLY; i++) xy2_dl_q[i] <= xy2_dl_q[i-1];
			for (int i = 1; i < TX2_DLY; i++) begin
				tx2_dl_q[i] <= tx2_dl_q[i-1];
				ty2_dl_q[i] <= ty2_dl_q[i-1];
			end
		end
	end

	logic signed [63:0] xr, yr, pa, pb, pc, pd;
	cpd_mul u_xr (.clk(clk), .en(en), .a(xn_dl_q[XN_DLY-1]), .b(rad_q), .p(xr));
	cpd_mul u_yr (.clk(clk), .en(en), .a(yn_dl_q[XN_DLY-1]), .b(rad_q), .p(yr));
	cpd_mul u_pa (.clk(clk), .en(en), .a(p1), .b(xy2_dl_q[XY2_DLY-1]), .p(pa));
	cpd_mul u_pb (.clk(clk), .en(en), .a(p2), .b(tx2_dl_q[TX2_DLY-1]), .p(pb));
	cpd_mul u_pc (.clk(clk), .en(en), .a(p1), .b(ty2_dl_q[TX2_DLY-1]), .p(pc));
	cpd_mul u_pd (.clk(clk), .en(en), .a(p2), .b(xy2_dl_q[XY2_DLY-1]), .p(pd));

	logic signed [63:0] tmpx_q, tmpy_q, xr_q, yr_q, xd_q, yd_q;
	always_ff @(posedge clk) begin
		if (en) begin
			tmpx_q <= sat_add(pa, pb);
			tmpy_q <= sat_add(pc, pd);
			xr_q   <= xr;
			yr_q   <= yr;
			xd_q   <= sat_add(xr_q, tmpx_q);
			yd_q   <= sat_add(yr_q, tmpy_q);
		end
	end

	// focal scaling, principal point, rounding
	logic signed [63:0] mx, my, cx_q, cy_q;
	logic signed [COL_W-1:0] col_q, row_q;
	cpd_mul u_fx (.clk(clk), .en(en), .a(xd_q), .b(fx), .p(mx));
	cpd_mul u_fy (.clk(clk), .en(en), .a(yd_q), .b(fy), .p(my));

	meta_t meta_end;
	logic  in_bounds;
	assign meta_end = meta_dl_q[META_DLY-1];
	assign in_bounds = (col_q >= $signed(COL_W'(0))) && (col_q < $signed(COL_W'(IMG_WIDTH)))
	             && (row_q >= $signed(COL_W'(0))) && (row_q < $signed(COL_W'(IMG_HEIGHT)));

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q  <= sat_add(mx, ctx);
			cy_q  <= sat_add(my, cty);
			col_q <= round_q16(cx_q);
			row_q <= round_q16(cy_q);
			out_item.pixel_col  <= meta_end.zpos ? sat16(col_q) : 16'sd0;
			out_item.pixel_row  <= meta_end.zpos ? sat16(row_q) : 16'sd0;
			out_item.depth_code <= meta_end.depth;
			out_item.in_view    <= meta_end.zpos && in_bounds;
		end
	end

endmodule
`default_nettype wire

/* design/camera_point_projection_distorted.sv */
// Top level of the distorted pinhole projection: configuration registers, front, queue, back.
// Depends on cpd_pkg, cpd_front, cpd_queue, cpd_back (and through it cpd_div, cpd_mul).
//
//   channel | signals                          | moves
//   input   | in_valid, in_stall, in_item      | one camera-frame point per item
//   output  | out_valid, out_stall, out_item   | pixel, depth code and view flag per item
//   config  | cfg_we, cfg_index, cfg_data      | one register write per cycle
//
// One item per cycle sustained while out_stall is low; the pipeline depth is set mostly by
// the 61-stage divider and six chained 5-stage multipliers in the back pipeline.
// Reset clears all valid state and loads the register defaults; no clearing pass.
// out_stall freezes the back pipeline while out_valid is high; the 4-entry queue keeps taking
// items until full, then in_stall rises while the front register holds an item.
`default_nettype none
module camera_point_projection_distorted (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cpd_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output cpd_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                       cfg_data
);
	import cpd_pkg::*;

	cfg_t  cfg_q;
	logic  push, q_full, pop, q_nonempty;
	qent_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x         <= 32'd32768000;
			cfg_q.focal_y         <= 32'd32768000;
			cfg_q.center_x        <= 32'd20971520;
			cfg_q.center_y        <= 32'd15728640;
			cfg_q.radial_k1       <= '0;
			cfg_q.radial_k2       <= '0;
			cfg_q.radial_k3       <= '0;
			cfg_q.tangential_pair <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:    cfg_q.focal_x         <= cfg_data[31:0];
				REG_FOCAL_Y:    cfg_q.focal_y         <= cfg_data[31:0];
				REG_CENTER_X:   cfg_q.center_x        <= cfg_data[31:0];
				REG_CENTER_Y:   cfg_q.center_y        <= cfg_data[31:0];
				REG_RADIAL_K1:  cfg_q.radial_k1       <= cfg_data[31:0];
				REG_RADIAL_K2:  cfg_q.radial_k2       <= cfg_data[31:0];
				REG_RADIAL_K3:  cfg_q.radial_k3       <= cfg_data[31:0];
				REG_TANGENTIAL: cfg_q.tangential_pair <= cfg_data;
				default: ;
			endcase
		end
	end

	cpd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.q_full(q_full), .push(push), .push_data(push_data)
	);

	cpd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(q_full),
		.pop(pop), .nonempty(q_nonempty), .pop_data(pop_data)
	);

	cpd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_nonempty(q_nonempty), .pop_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

endmodule
`default_nettype wire

/* tb/sv/tb_camera_point_projection_distorted.sv */
// Testbench for the distorted pinhole projection block: directed and random points under
// several camera settings, checked against an in-bench fixed-point predictor. Needs cpd_pkg.
`timescale 1ns / 1ps
module tb_camera_point_projection_distorted;
	import cpd_pkg::*;

	localparam logic signed [63:0] QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int MAX_CYCLES = 2000000;
	localparam int DRAIN = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	camera_point_projection_distorted dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// camera settings as the predictor sees them
	logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy;
	logic signed [31:0] cam_k1, cam_k2, cam_k3;
	logic [63:0] cam_tan;

	in_item_t point_q[$];
	out_item_t pixel_q[$];
	int errors = 0;
	int cycles = 0;

	function automatic logic signed [63:0] clampq(input logic signed [127:0] v);
		if (v > 128'(QLIM)) return QLIM;
		if (v < -128'(QLIM)) return -QLIM;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] addq(input logic signed [63:0] a,
	                                            input logic signed [63:0] b);
		return clampq(128'(clampq(128'(a))) + 128'(clampq(128'(b))));
	endfunction

	// exact product, >>28 half away from zero, saturated
	function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
	                                            input logic signed [63:0] b);
		logic [127:0] ma, mb, p;
		logic neg;
		ma = (a < 0) ? 128'(-clampq(128'(a))) : 128'(clampq(128'(a)));
		mb = (b < 0) ? 128'(-clampq(128'(b))) : 128'(clampq(128'(b)));
		neg = (a < 0) != (b < 0);
		p = (ma * mb + (128'd1 << 27)) >> 28;
		if (p > 128'(QLIM)) p = 128'(QLIM);
		return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	function automatic logic signed [63:0] normq(input logic signed [63:0] num,
	                                             input logic signed [63:0] den);
		logic [127:0] m, q;
		m = (num < 0) ? 128'(-num) : 128'(num);
		q = ((m << 29) + 128'(den)) / (128'(den) << 1);
		return (num < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [63:0] pixel_round(input logic signed [63:0] v);
		logic [63:0] m;
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + 64'h8000) >> 16;
		return (v < 0) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [15:0] clip16(input logic signed [63:0] v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic out_item_t project(input in_item_t p);
		out_item_t r;
		logic signed [63:0] x, y, z, p1, p2, xn, yn, xx, yy, xy2, r2, r4, r6, rad, xd, yd;
		logic signed [63:0] col, row;
		logic [63:0] dq;
		r = '0;
		x = p.point_x; y = p.point_y; z = p.point_z;
		if (z <= 0) return r;
		p1 = $signed(cam_tan[63:32]);
		p2 = $signed(cam_tan[31:0]);
		xn = normq(x, z);
		yn = normq(y, z);
		xx = mulq(xn, xn);
		yy = mulq(yn, yn);
		xy2 = addq(mulq(xn, yn), mulq(xn, yn));
		r2 = addq(xx, yy);
		r4 = mulq(r2, r2);
		r6 = mulq(r4, r2);
		rad = addq(addq(64'sd1 << 28, mulq(64'(cam_k1), r2)),
			addq(mulq(64'(cam_k2), r4), mulq(64'(cam_k3), r6)));
		xd = addq(mulq(xn, rad), addq(mulq(p1, xy2), mulq(p2, addq(r2, addq(xx, xx)))));
		yd = addq(mulq(yn, rad), addq(mulq(p1, addq(r2, addq(yy, yy))), mulq(p2, xy2)));
		col = pixel_round(addq(mulq(xd, $signed({32'd0, cam_fx})), $signed({32'd0, cam_cx})));
		row = pixel_round(addq(mulq(yd, $signed({32'd0, cam_fy})), $signed({32'd0, cam_cy})));
		dq = (64'(z) * 64'd1000 + 64'h8000) >> 16;
		if (dq > 65535) dq = 65535;
		r.pixel_col = clip16(col);
		r.pixel_row = clip16(row);
		r.depth_code = dq[15:0];
		r.in_view = (col >= 0 && col < 640 && row >= 0 && row < 480);
		return r;
	endfunction

	// driver: bursts and gaps; the item on the bus stays at the head of point_q until taken
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pixel_q.insert(pixel_q.size(), project(in_item));
				void'(point_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (point_q.size() > 0) begin
					in_valid <= 1'b1;
					in_item <= point_q[0];
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern and checker
	int stall_mode = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= (cycles % 7) < 5;
			endcase
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected result %p", out_item);
				end else begin
					if (out_item !== pixel_q[0]) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %p got %p", pixel_q[0], out_item);
					end
					void'(pixel_q.pop_front());
				end
			end
		end
		if (cycles > MAX_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FOCAL_X: cam_fx = val[31:0];
			REG_FOCAL_Y: cam_fy = val[31:0];
			REG_CENTER_X: cam_cx = val[31:0];
			REG_CENTER_Y: cam_cy = val[31:0];
			REG_RADIAL_K1: cam_k1 = val[31:0];
			REG_RADIAL_K2: cam_k2 = val[31:0];
			REG_RADIAL_K3: cam_k3 = val[31:0];
			default: cam_tan = val;
		endcase
	endtask

	task automatic wait_idle();
		while (point_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		in_item_t p;
		p.point_x = x; p.point_y = y; p.point_z = z;
		point_q.insert(point_q.size(), p);
	endtask

	// random point: mostly sensible in-front geometry, some raw noise
	task automatic add_random_point();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			add_point($signed($urandom_range(0, 262144)) - 131072,
				$signed($urandom_range(0, 196608)) - 98304, $urandom_range(13107, 1310720));
		end else if (sel < 8) begin
			add_point($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF));
		end else begin
			add_point($urandom, $urandom, $urandom);
		end
	endtask

	task automatic run_phase(input int n);
		repeat (n) add_random_point();
		wait_idle();
	endtask

	initial begin
		cam_fx = 32'd32768000; cam_fy = 32'd32768000;
		cam_cx = 32'd20971520; cam_cy = 32'd15728640;
		cam_k1 = '0; cam_k2 = '0; cam_k3 = '0; cam_tan = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero and negative depth, extremes, edges of the image, saturation
		add_point(0, 0, 32'h0001_0000);
		add_point(0, 0, 0);
		add_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
		add_point(32'h8000_0000, 32'h8000_0000, 1);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_point(32'hFFFF_FFFF, 1, 32'h7FFF_FFFF);
		add_point(32'hFFFF_6000, 32'hFFFF_8500, 32'h0001_0000);
		add_point(32'h0000_9FFF, 32'h0000_77FF, 32'h0001_0000);
		add_point(32'h0000_A000, 32'h0000_7800, 32'h0001_0000);
		add_point(32'h0000_8000, 32'h0000_8000, 32'h0000_0021);
		add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
		wait_idle();

		write_reg(REG_RADIAL_K1, 64'h0000_0000_FC00_0000);
		write_reg(REG_RADIAL_K2, 64'h0000_0000_0100_0000);
		write_reg(REG_RADIAL_K3, 64'h0000_0000_FFF0_0000);
		write_reg(REG_TANGENTIAL, 64'h0004_0000_FFFC_0000);
		run_phase(100);

		write_reg(REG_FOCAL_X, 64'hFFFF_FFFF);
		write_reg(REG_FOCAL_Y, 64'd1);
		write_reg(REG_CENTER_X, 64'hFFFF_FFFF);
		write_reg(REG_CENTER_Y, 64'd0);
		write_reg(REG_RADIAL_K1, 64'h7FFF_FFFF);
		write_reg(REG_RADIAL_K2, 64'h8000_0000);
		write_reg(REG_RADIAL_K3, 64'h7FFF_FFFF);
		write_reg(REG_TANGENTIAL, 64'h8000_0000_7FFF_FFFF);
		run_phase(80);

		write_reg(REG_FOCAL_X, {32'd0, $urandom_range(32'h0010_0000, 32'h0800_0000)});
		write_reg(REG_FOCAL_Y, {32'd0, $urandom_range(32'h0010_0000, 32'h0800_0000)});
		write_reg(REG_CENTER_X, {32'd0, $urandom_range(0, 32'h0400_0000)});
		write_reg(REG_CENTER_Y, {32'd0, $urandom_range(0, 32'h0300_0000)});
		write_reg(REG_RADIAL_K1, {32'd0, $urandom});
		write_reg(REG_RADIAL_K2, {32'd0, $urandom});
		write_reg(REG_RADIAL_K3, {32'd0, $urandom});
		write_reg(REG_TANGENTIAL, {$urandom, $urandom});
		run_phase(100);

		write_reg(REG_FOCAL_X, 64'd32768000);
		write_reg(REG_FOCAL_Y, 64'd32768000);
		write_reg(REG_CENTER_X, 64'd20971520);
		write_reg(REG_CENTER_Y, 64'd15728640);
		write_reg(REG_RADIAL_K1, 64'h0000_0000_0200_0000);
		write_reg(REG_RADIAL_K2, 64'h0);
		write_reg(REG_RADIAL_K3, 64'h0);
		write_reg(REG_TANGENTIAL, 64'h0);
		run_phase(120);

		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
design/cpd_pkg.sv
design/cpd_mul.sv
design/cpd_div.sv
design/cpd_queue.sv
design/cpd_front.sv
design/cpd_back.sv
design/camera_point_projection_distorted.sv
tb/sv/tb_camera_point_projection_distorted.sv
